// ===== src/skcd_pkg.sv =====
// Package for the servo key command decoder.
// Holds the duty and store types, key codes, flag bit positions and stream widths.
// No dependencies; every other file refers to it by scoped names.
package skcd_pkg;

    // Sizes of the servo set and of the move store.
    localparam int NSERVO    = 5;
    localparam int DUTY_BITS = 11;
    localparam int MAX_MOVES = 16;
    localparam int SEL_BITS  = 3;
    localparam int MOVE_BITS = 4;
    localparam int CNT_BITS  = 5;
    localparam int FLAG_BITS = 5;

    typedef logic [DUTY_BITS-1:0]             t_duty;
    typedef logic [NSERVO-1:0][DUTY_BITS-1:0] t_move;
    typedef logic [SEL_BITS-1:0]              t_sel;
    typedef logic [MOVE_BITS-1:0]             t_move_idx;
    typedef logic [CNT_BITS-1:0]              t_count;
    typedef logic [FLAG_BITS-1:0]             t_flags;

    // Duty reset values and the key step size.
    localparam t_duty DUTY_INIT = t_duty'(812);
    localparam t_duty LOW_INIT  = t_duty'(312);
    localparam t_duty HIGH_INIT = t_duty'(1312);
    localparam t_duty DUTY_STEP = t_duty'(10);

    // Mode flag bit positions.
    localparam int FL_CAL   = 0;
    localparam int FL_REC   = 1;
    localparam int FL_DONE  = 2;
    localparam int FL_PLAY  = 3;
    localparam int FL_START = 4;

    // Key codes after case folding.
    localparam logic [7:0] KEY_STOP    = 8'h70;  // p
    localparam logic [7:0] KEY_START   = 8'h63;  // c
    localparam logic [7:0] KEY_CRONO   = 8'h69;  // i
    localparam logic [7:0] KEY_UP      = 8'h73;  // s
    localparam logic [7:0] KEY_DOWN    = 8'h64;  // d
    localparam logic [7:0] KEY_JOY     = 8'h6D;  // m
    localparam logic [7:0] KEY_CAL     = 8'h71;  // q
    localparam logic [7:0] KEY_SET_LO  = 8'h65;  // e
    localparam logic [7:0] KEY_SET_HI  = 8'h72;  // r
    localparam logic [7:0] KEY_CAL_END = 8'h77;  // w
    localparam logic [7:0] KEY_REC     = 8'h66;  // f
    localparam logic [7:0] KEY_GRAB    = 8'h67;  // g
    localparam logic [7:0] KEY_REC_END = 8'h68;  // h
    localparam logic [7:0] KEY_PLAY    = 8'h6A;  // j
    localparam logic [7:0] KEY_SEL1    = 8'h31;
    localparam logic [7:0] KEY_SEL2    = 8'h32;
    localparam logic [7:0] KEY_SEL3    = 8'h33;
    localparam logic [7:0] KEY_SEL4    = 8'h34;
    localparam logic [7:0] KEY_SEL5    = 8'h35;
    localparam logic [7:0] KEY_UPPER_A = 8'h41;
    localparam logic [7:0] KEY_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // Request kinds carried in the slave-side tuser.
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Stream widths.
    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_FIELD_BITS = 3 + SEL_BITS + 4 * DUTY_BITS + FLAG_BITS + CNT_BITS;
    localparam int OUT_TDATA_BITS = 64;

endpackage

// ===== src/servo_key_command_decoder.sv =====
// Top level of the servo key command decoder: key decode, servo state and move store.
// Depends on skcd_pkg for types, key codes and widths.
//
// Usage:
// The slave-side stream carries one request per transaction: a key press
// (tuser 0) or a read of one recorded duty (tuser 1). Every accepted request
// gives exactly one result transaction on the master side, carrying the timer,
// joystick and mode state, the selected servo with its duty and limits, the
// recorded move count and, for reads, the stored duty.
// The state registers are updated at the accepting edge and the result is valid
// in the next cycle. The state registers themselves serve as the result register,
// with the read data and the restart pulse held beside them, so the block takes
// one request per cycle for as long as the receiver takes results.
// When the receiver stalls, the result holds and tready drops until the
// result is taken; the request offered in the cycle it is taken is accepted.
// Synchronous reset restores the duties to 812 with limits 312 and 1312,
// selects servo 1, clears all modes and the move count and empties the result
// register. The move store is not cleared; only moves recorded since the last
// record start can be read.
module servo_key_command_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: key_code[7:0], read_move[11:8], read_servo[14:12], zero [15].
    input  logic [skcd_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // tuser: req_type.
    input  logic        i_s_axis_tuser,
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: timer_run[0], crono_restart[1], joystick_mode[2], servo_sel[5:3],
    // duty_value[16:6], duty_low_limit[27:17], duty_high_limit[38:28],
    // mode_flags[43:39], move_count[48:44], read_data[59:49], zero [63:60].
    output logic [skcd_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    // Servo and mode state.
    skcd_pkg::t_duty     r_duty  [skcd_pkg::NSERVO];
    skcd_pkg::t_duty     r_low   [skcd_pkg::NSERVO];
    skcd_pkg::t_duty     r_high  [skcd_pkg::NSERVO];
    skcd_pkg::t_duty     n_duty  [skcd_pkg::NSERVO];
    skcd_pkg::t_duty     n_low   [skcd_pkg::NSERVO];
    skcd_pkg::t_duty     n_high  [skcd_pkg::NSERVO];
    skcd_pkg::t_sel      r_sel,   n_sel;
    logic                r_joy,   n_joy;
    logic                r_timer, n_timer;
    skcd_pkg::t_flags    r_flags, n_flags;
    skcd_pkg::t_move_idx r_widx,  n_widx;
    skcd_pkg::t_count    r_count, n_count;

    // Result side.
    logic                r_out_valid;
    logic                r_pulse,  n_pulse;
    skcd_pkg::t_move     r_rd_word;
    skcd_pkg::t_sel      r_rd_servo;
    logic                r_rd_hit;

    // Move store.
    skcd_pkg::t_move     r_moves [skcd_pkg::MAX_MOVES];

    logic                w_accept;
    logic                w_key_acc;
    logic                w_store;
    logic [7:0]          w_key;
    skcd_pkg::t_move_idx w_rd_move;
    skcd_pkg::t_sel      w_rd_servo;
    skcd_pkg::t_duty     w_cur_duty;
    skcd_pkg::t_duty     w_cur_low;
    skcd_pkg::t_duty     w_cur_high;
    logic [skcd_pkg::DUTY_BITS:0] w_up;
    logic [skcd_pkg::DUTY_BITS:0] w_low_step;
    skcd_pkg::t_move     w_snapshot;
    skcd_pkg::t_duty     w_rdata;

    // Handshake: the result register is free when empty or being taken.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_key_acc       = w_accept && (i_s_axis_tuser == skcd_pkg::REQ_KEY);
    assign w_rd_move       = i_s_axis_tdata[11:8];
    assign w_rd_servo      = i_s_axis_tdata[14:12];

    // Fold upper-case letters to lower case.
    always_comb begin
        w_key = i_s_axis_tdata[7:0];
        if (w_key >= skcd_pkg::KEY_UPPER_A && w_key <= skcd_pkg::KEY_UPPER_Z) begin
            w_key = w_key | skcd_pkg::CASE_BIT;
        end
    end

    // Selected servo values and the step comparisons.
    assign w_cur_duty = r_duty[r_sel];
    assign w_cur_low  = r_low[r_sel];
    assign w_cur_high = r_high[r_sel];
    assign w_up       = {1'b0, w_cur_duty} + {1'b0, skcd_pkg::DUTY_STEP};
    assign w_low_step = {1'b0, w_cur_low} + {1'b0, skcd_pkg::DUTY_STEP};

    always_comb begin
        for (int k = 0; k < skcd_pkg::NSERVO; k++) begin
            w_snapshot[k] = r_duty[k];
        end
    end

    // Next state for a key press.
    always_comb begin
        n_duty  = r_duty;
        n_low   = r_low;
        n_high  = r_high;
        n_sel   = r_sel;
        n_joy   = r_joy;
        n_timer = r_timer;
        n_flags = r_flags;
        n_widx  = r_widx;
        n_count = r_count;
        n_pulse = 1'b0;
        w_store = 1'b0;
        unique case (w_key)
            skcd_pkg::KEY_STOP:  n_timer = 1'b0;
            skcd_pkg::KEY_START: n_timer = 1'b1;
            skcd_pkg::KEY_CRONO: n_pulse = 1'b1;
            skcd_pkg::KEY_UP: begin
                if (!r_joy && w_up <= {1'b0, w_cur_high}) begin
                    n_duty[r_sel] = w_up[skcd_pkg::DUTY_BITS-1:0];
                end
            end
            skcd_pkg::KEY_DOWN: begin
                if (!r_joy && {1'b0, w_cur_duty} >= w_low_step) begin
                    n_duty[r_sel] = w_cur_duty - skcd_pkg::DUTY_STEP;
                end
            end
            skcd_pkg::KEY_JOY: n_joy = !r_joy;
            skcd_pkg::KEY_CAL: begin
                n_flags[skcd_pkg::FL_CAL] = 1'b1;
                n_low[r_sel]  = skcd_pkg::LOW_INIT;
                n_high[r_sel] = skcd_pkg::HIGH_INIT;
            end
            skcd_pkg::KEY_SET_LO: begin
                if (r_flags[skcd_pkg::FL_CAL]) begin
                    n_low[r_sel] = w_cur_duty;
                end
            end
            skcd_pkg::KEY_SET_HI: begin
                if (r_flags[skcd_pkg::FL_CAL]) begin
                    n_high[r_sel] = w_cur_duty;
                end
            end
            skcd_pkg::KEY_CAL_END: n_flags[skcd_pkg::FL_CAL] = 1'b0;
            skcd_pkg::KEY_REC: begin
                n_flags[skcd_pkg::FL_REC] = 1'b1;
                n_widx  = '0;
                n_count = '0;
            end
            skcd_pkg::KEY_GRAB: begin
                // The write index never passes the last entry, so only the
                // recording flag gates a snapshot.
                if (r_flags[skcd_pkg::FL_REC]) begin
                    w_store = 1'b1;
                    n_widx  = r_widx + 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_widx == skcd_pkg::t_move_idx'(skcd_pkg::MAX_MOVES - 1)) begin
                        n_flags[skcd_pkg::FL_REC]   = 1'b0;
                        n_flags[skcd_pkg::FL_DONE]  = 1'b1;
                        n_flags[skcd_pkg::FL_START] = 1'b1;
                        n_widx = '0;
                        n_joy  = 1'b0;
                    end
                end
            end
            skcd_pkg::KEY_REC_END: begin
                n_flags[skcd_pkg::FL_REC]   = 1'b0;
                n_flags[skcd_pkg::FL_DONE]  = 1'b1;
                n_flags[skcd_pkg::FL_START] = 1'b1;
                n_widx = '0;
                n_joy  = 1'b0;
            end
            skcd_pkg::KEY_PLAY: begin
                if (!r_flags[skcd_pkg::FL_PLAY]) begin
                    n_flags[skcd_pkg::FL_PLAY]  = 1'b1;
                    n_flags[skcd_pkg::FL_START] = 1'b1;
                    n_joy = 1'b0;
                end
            end
            skcd_pkg::KEY_SEL1: n_sel = skcd_pkg::t_sel'(0);
            skcd_pkg::KEY_SEL2: n_sel = skcd_pkg::t_sel'(1);
            skcd_pkg::KEY_SEL3: n_sel = skcd_pkg::t_sel'(2);
            skcd_pkg::KEY_SEL4: n_sel = skcd_pkg::t_sel'(3);
            skcd_pkg::KEY_SEL5: n_sel = skcd_pkg::t_sel'(4);
            default: ;
        endcase
    end

    // Control and servo state registers; they also form the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < skcd_pkg::NSERVO; k++) begin
                r_duty[k] <= skcd_pkg::DUTY_INIT;
                r_low[k]  <= skcd_pkg::LOW_INIT;
                r_high[k] <= skcd_pkg::HIGH_INIT;
            end
            r_sel       <= '0;
            r_joy       <= 1'b0;
            r_timer     <= 1'b0;
            r_flags     <= '0;
            r_widx      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_key_acc) begin
                r_duty  <= n_duty;
                r_low   <= n_low;
                r_high  <= n_high;
                r_sel   <= n_sel;
                r_joy   <= n_joy;
                r_timer <= n_timer;
                r_flags <= n_flags;
                r_widx  <= n_widx;
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: restart pulse and registered store read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pulse    <= w_key_acc && n_pulse;
            r_rd_word  <= r_moves[w_rd_move];
            r_rd_servo <= w_rd_servo;
            r_rd_hit   <= (i_s_axis_tuser == skcd_pkg::REQ_READ)
                       && ({1'b0, w_rd_move} < r_count)
                       && (w_rd_servo < skcd_pkg::t_sel'(skcd_pkg::NSERVO));
        end
    end

    // Move store write: a snapshot of all five duties.
    always_ff @(posedge i_clk) begin
        if (w_key_acc && w_store) begin
            r_moves[r_widx] <= w_snapshot;
        end
    end

    assign w_rdata = r_rd_hit ? r_rd_word[r_rd_servo] : '0;

    // Result transaction.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        {(skcd_pkg::OUT_TDATA_BITS - skcd_pkg::OUT_FIELD_BITS){1'b0}},
        w_rdata, r_count, r_flags,
        w_cur_high, w_cur_low, w_cur_duty,
        r_sel, r_joy, r_pulse, r_timer
    };

endmodule

// ===== src/skcd_checker.sv =====
// Port-level checker for the servo key command decoder, bound to the top level.
// Depends on skcd_pkg for stream widths and on the top level's port list.
module skcd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [skcd_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata
);

    // A stalled result holds its valid and its data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Requests are taken exactly when the result register is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("request ready does not follow the result side");

    // Every accepted request gives a result in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted request gave no result");

    // Selected servo stays within the five servos and the count within the store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[5:3] <= 3'd4) && (o_m_axis_tdata[48:44] <= 5'd16))
        else $error("servo index or move count out of range");

endmodule

bind servo_key_command_decoder skcd_checker u_skcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
